/* src/imd_pkg.sv */
// imd_pkg: widths, constants, codes and controller/datapath link types
// for the metal detector baseline tracker; no dependencies
package imd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SKIP_LIMIT  = 64;

  localparam int CNT_W       = 10;
  localparam int LIMIT_W     = 20;
  localparam int MAX_COUNT   = 1022;
  localparam int IDX_W       = 10;
  localparam int SUM_W       = SAMPLE_BITS + IDX_W + 1;
  localparam int BASE_W      = 32;
  localparam int BASE_SHIFT  = 6;
  localparam int ROUND_HALF  = 32;
  localparam int ADAPT_SHIFT = 10;
  localparam int AVG_W       = BASE_W + 1 - BASE_SHIFT;
  localparam int DIFF_W      = ((SUM_W > AVG_W) ? SUM_W : AVG_W) + 1;
  localparam int MAG_W       = DIFF_W - 1;
  localparam int DVS_W       = MAG_W + 1;
  localparam int SKIP_W      = 7;
  localparam int ZERO_PERIOD = 1000000;
  localparam int DIV_STEPS   = AVG_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam int TS_OUT_W    = 22;
  localparam int AVG_OUT_W   = 22;
  localparam int DIFF_OUT_W  = 23;
  localparam int PER_OUT_W   = 22;
  localparam int DIR_W       = 2;

  localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = TS_OUT_W + AVG_OUT_W + DIFF_OUT_W + PER_OUT_W + DIR_W + 1;
  localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEADY_LIMIT = 1'b1;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RISE = 2'd1;
  localparam logic [DIR_W-1:0] DIR_FALL = 2'd2;

  typedef struct packed {
    logic acc;
    logic trim;
    logic seed;
    logic avg;
    logic diff;
    logic adapt;
    logic step;
    logic load_out;
  } imd_cmd_t;

  typedef struct packed {
    logic blk_end;
  } imd_sts_t;

endpackage

/* src/imd_ctrl.sv */
// imd_ctrl: sequencer for sample intake, block-end update and divider steps
// depends on imd_pkg
module imd_ctrl import imd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  logic     m_ready_i,
  output logic     m_valid_o,
  input  imd_sts_t sts_i,
  output imd_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIM,
    S_SEED,
    S_AVG,
    S_DIFF,
    S_ADAPT,
    S_DIV,
    S_OUT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              m_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:  cmd_o.acc      = s_valid_i;
      S_TRIM:  cmd_o.trim     = 1'b1;
      S_SEED:  cmd_o.seed     = 1'b1;
      S_AVG:   cmd_o.avg      = 1'b1;
      S_DIFF:  cmd_o.diff     = 1'b1;
      S_ADAPT: cmd_o.adapt    = 1'b1;
      S_DIV:   cmd_o.step     = 1'b1;
      S_OUT:   cmd_o.load_out = !m_valid_q || m_ready_i;
      default: cmd_o = '0;
    endcase
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_valid_i && sts_i.blk_end) state_q <= S_TRIM;
        end
        S_TRIM:  state_q <= S_SEED;
        S_SEED:  state_q <= S_AVG;
        S_AVG:   state_q <= S_DIFF;
        S_DIFF:  state_q <= S_ADAPT;
        S_ADAPT: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_STEPS - 1)) state_q <= S_OUT;
        end
        S_OUT: begin
          if (cmd_o.load_out) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/imd_dp.sv */
// imd_dp: config registers, block accumulators, baseline tracker,
// restoring divider and result register; depends on imd_pkg
module imd_dp import imd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [LIMIT_W-1:0]           cfg_wdata_i,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  imd_cmd_t                     cmd_i,
  output imd_sts_t                     sts_o,
  output logic [TS_OUT_W-1:0]          trimmed_sum_o,
  output logic [AVG_OUT_W-1:0]         average_o,
  output logic signed [DIFF_OUT_W-1:0] difference_o,
  output logic [PER_OUT_W-1:0]         blink_period_o,
  output logic [DIR_W-1:0]             direction_o,
  output logic                         green_led_o
);

  logic [CNT_W-1:0]         cnt_cfg_q;
  logic [LIMIT_W-1:0]       limit_q;
  logic [SUM_W-1:0]         sum_q;
  logic [SAMPLE_BITS-1:0]   min_q;
  logic [SAMPLE_BITS-1:0]   max_q;
  logic [IDX_W-1:0]         idx_q;
  logic [SUM_W-1:0]         trim_q;
  logic [BASE_W-1:0]        base_q;
  logic [SKIP_W-1:0]        skip_q;
  logic [AVG_W-1:0]         avg_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [DVS_W-1:0]         dvs_q;
  logic [DVS_W-1:0]         rem_q;
  logic [AVG_W-1:0]         quo_q;

  logic [CNT_W-1:0]         cnt_eff;
  logic [IDX_W:0]           idx_nxt;
  logic [BASE_W-1:0]        seed_val;
  logic [BASE_W:0]          avg_sum;
  logic signed [DIFF_W-1:0] diff_neg;
  logic [MAG_W-1:0]         mag;
  logic                     adapt_ok;
  logic [BASE_W-1:0]        base_adp;
  logic [SKIP_W-1:0]        skip_inc;
  logic                     rebase;
  logic [DVS_W:0]           shifted;
  logic [DVS_W:0]           sub;
  logic                     ge;
  logic [AVG_W-1:0]         period;
  logic [DIR_W-1:0]         dir;

  always_comb begin
    cnt_eff  = (cnt_cfg_q > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : cnt_cfg_q;
    idx_nxt  = {1'b0, idx_q} + (IDX_W + 1)'(1);
    sts_o.blk_end = (idx_nxt >= ({1'b0, cnt_eff} + (IDX_W + 1)'(2)));

    seed_val = BASE_W'(trim_q) << BASE_SHIFT;
    avg_sum  = {1'b0, base_q} + (BASE_W + 1)'(ROUND_HALF);

    diff_neg = -diff_q;
    mag      = diff_q[DIFF_W-1] ? MAG_W'(diff_neg) : MAG_W'(diff_q);
    adapt_ok = (mag < MAG_W'(avg_q >> ADAPT_SHIFT));
    base_adp = base_q + BASE_W'(diff_q);
    skip_inc = skip_q + SKIP_W'(1);
    rebase   = !adapt_ok && (skip_inc > SKIP_W'(SKIP_LIMIT));

    shifted  = {rem_q, quo_q[AVG_W-1]};
    sub      = shifted - {1'b0, dvs_q};
    ge       = (shifted >= {1'b0, dvs_q});

    period   = (diff_q == '0) ? AVG_W'(ZERO_PERIOD) : quo_q;
    if (diff_q == '0) begin
      dir = DIR_NONE;
    end else if (diff_q[DIFF_W-1]) begin
      dir = DIR_FALL;
    end else begin
      dir = DIR_RISE;
    end
    if (period > AVG_W'(limit_q)) dir = DIR_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_cfg_q <= CNT_W'(256);
      limit_q   <= LIMIT_W'(400);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SAMPLE_COUNT: cnt_cfg_q <= cfg_wdata_i[CNT_W-1:0];
        REG_STEADY_LIMIT: limit_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // block accumulators and baseline state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      min_q  <= '1;
      max_q  <= '0;
      idx_q  <= '0;
      base_q <= '0;
      skip_q <= '0;
    end else begin
      if (cmd_i.acc) begin
        sum_q <= sum_q + SUM_W'(sample_i);
        if (sample_i < min_q) min_q <= sample_i;
        if (sample_i > max_q) max_q <= sample_i;
        idx_q <= idx_nxt[IDX_W-1:0];
      end
      if (cmd_i.trim) begin
        sum_q <= '0;
        min_q <= '1;
        max_q <= '0;
        idx_q <= '0;
      end
      if (cmd_i.seed && base_q == '0) base_q <= seed_val;
      if (cmd_i.adapt) begin
        if (adapt_ok) begin
          base_q <= base_adp;
          skip_q <= '0;
        end else if (rebase) begin
          base_q <= seed_val;
          skip_q <= '0;
        end else begin
          skip_q <= skip_inc;
        end
      end
    end
  end

  // block-end arithmetic, divider and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.trim) trim_q <= sum_q - SUM_W'(min_q) - SUM_W'(max_q);
    if (cmd_i.avg)  avg_q  <= avg_sum[BASE_W:BASE_SHIFT];
    if (cmd_i.diff) diff_q <= DIFF_W'(trim_q) - DIFF_W'(avg_q);
    if (cmd_i.adapt) begin
      dvs_q <= {mag, 1'b0};
      rem_q <= '0;
      quo_q <= avg_q;
    end
    if (cmd_i.step) begin
      rem_q <= ge ? sub[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_q <= {quo_q[AVG_W-2:0], ge};
    end
    if (cmd_i.load_out) begin
      trimmed_sum_o  <= TS_OUT_W'(trim_q);
      average_o      <= AVG_OUT_W'(avg_q);
      difference_o   <= DIFF_OUT_W'(diff_q);
      blink_period_o <= PER_OUT_W'(period);
      direction_o    <= dir;
      green_led_o    <= (dir != DIR_NONE);
    end
  end

endmodule

/* src/inductive_metal_detect_tracker.sv */
// inductive_metal_detect_tracker: top level, stream ports and config port
// around imd_ctrl and imd_dp; depends on imd_pkg
//
// channel   direction  beat content
// s_axis    in         one adc sample
// m_axis    out        one result per block
// cfg       in         register write, no read-back
//
// a sample is taken every cycle while no block end is in progress
// the last sample of a block stalls input through 5 update steps,
// 27 restoring divider iterations for the flash period and 1 result load
// result load waits while a previous result is still held on m_axis
// reset clears accumulators, baseline and skip count; registers return to defaults
module inductive_metal_detect_tracker import imd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // trimmed_sum, average, difference, blink_period, direction, green_led
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [LIMIT_W-1:0]    cfg_wdata_i
);

  imd_cmd_t                     cmd;
  imd_sts_t                     sts;
  logic [TS_OUT_W-1:0]          trimmed_sum;
  logic [AVG_OUT_W-1:0]         average;
  logic signed [DIFF_OUT_W-1:0] difference;
  logic [PER_OUT_W-1:0]         blink_period;
  logic [DIR_W-1:0]             direction;
  logic                         green_led;

  imd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  imd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_i       (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .trimmed_sum_o  (trimmed_sum),
    .average_o      (average),
    .difference_o   (difference),
    .blink_period_o (blink_period),
    .direction_o    (direction),
    .green_led_o    (green_led)
  );

  assign m_axis_tdata = {{(M_TDATA_W - OUT_BITS){1'b0}}, green_led, direction,
                         blink_period, difference, average, trimmed_sum};

endmodule

/* bench/tb_inductive_metal_detect_tracker.sv */
// tb_inductive_metal_detect_tracker: self-checking bench for the baseline tracker,
// sample runs are checked block by block against a predictor held in a scoreboard class
// depends on imd_pkg and inductive_metal_detect_tracker
module tb_inductive_metal_detect_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import imd_pkg::*;

  localparam int FULL_SCALE = (1 << SAMPLE_BITS) - 1;

  typedef struct packed {
    logic                  green_led;
    logic [DIR_W-1:0]      direction;
    logic [PER_OUT_W-1:0]  blink_period;
    logic [DIFF_OUT_W-1:0] difference;
    logic [AVG_OUT_W-1:0]  average;
    logic [TS_OUT_W-1:0]   trimmed_sum;
  } block_result_t;

  class baseline_scoreboard;
    logic [CNT_W-1:0]   count_reg;
    logic [LIMIT_W-1:0] limit_reg;
    bit [31:0]          blk_sum, blk_min, blk_max, blk_pos, baseline, skips;
    block_result_t      due_results[$];
    int                 failures;

    function new();
      count_reg = CNT_W'(256);
      limit_reg = LIMIT_W'(400);
      baseline  = 0;
      skips     = 0;
      failures  = 0;
      restart_block();
    endfunction

    function void restart_block();
      blk_sum = 0;
      blk_min = FULL_SCALE;
      blk_max = 0;
      blk_pos = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] data);
      if (idx == REG_SAMPLE_COUNT) begin
        count_reg = data[CNT_W-1:0];
      end else begin
        limit_reg = data;
      end
    endfunction

    function void fold_sample(logic [SAMPLE_BITS-1:0] smp);
      bit [31:0]        blk_len, tsum, avg, mag, period;
      longint           diff;
      logic [DIR_W-1:0] dir;
      block_result_t    r;
      blk_len = (count_reg > MAX_COUNT) ? MAX_COUNT : count_reg;
      if (smp < blk_min) blk_min = smp;
      if (smp > blk_max) blk_max = smp;
      blk_sum += smp;
      blk_pos += 1;
      if (blk_pos < blk_len + 2) return;

      tsum = blk_sum - blk_min - blk_max;
      restart_block();
      if (baseline == 0) baseline = tsum << BASE_SHIFT;
      avg  = 32'(({32'd0, baseline} + 64'(ROUND_HALF)) >> BASE_SHIFT);
      diff = longint'({32'd0, tsum}) - longint'({32'd0, avg});
      mag  = (diff < 0) ? 32'(-diff) : 32'(diff);
      if (mag < (avg >> ADAPT_SHIFT)) begin
        baseline = baseline + tsum - avg;
        skips    = 0;
      end else begin
        skips += 1;
      end
      if (skips > SKIP_LIMIT) begin
        baseline = tsum << BASE_SHIFT;
        skips    = 0;
      end
      period = (mag == 0) ? 32'(ZERO_PERIOD) : 32'({32'd0, avg} / ({32'd0, mag} << 1));
      dir = DIR_NONE;
      if (diff > 0) dir = DIR_RISE;
      else if (diff < 0) dir = DIR_FALL;
      if (period > limit_reg) dir = DIR_NONE;

      r.trimmed_sum  = tsum[TS_OUT_W-1:0];
      r.average      = avg[AVG_OUT_W-1:0];
      r.difference   = diff[DIFF_OUT_W-1:0];
      r.blink_period = period[PER_OUT_W-1:0];
      r.direction    = dir;
      r.green_led    = (dir != DIR_NONE);
      due_results.push_back(r);
    endfunction

    function string show(block_result_t r);
      return $sformatf("sum=%0d avg=%0d diff=%0d period=%0d dir=%0d led=%0d",
                       r.trimmed_sum, r.average, $signed(r.difference),
                       r.blink_period, r.direction, r.green_led);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] beat);
      block_result_t got, want;
      string         bad;
      got = block_result_t'(beat[OUT_BITS-1:0]);
      bad = "";
      want = '0;
      if (due_results.size() == 0) begin
        bad = " no result pending";
      end else begin
        want = due_results.pop_front();
        if (got.trimmed_sum !== want.trimmed_sum)   bad = {bad, " trimmed_sum"};
        if (got.average !== want.average)           bad = {bad, " average"};
        if (got.difference !== want.difference)     bad = {bad, " difference"};
        if (got.blink_period !== want.blink_period) bad = {bad, " blink_period"};
        if (got.direction !== want.direction)       bad = {bad, " direction"};
        if (got.green_led !== want.green_led)       bad = {bad, " green_led"};
      end
      if (bad != "") begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch at %0t:%s", $realtime, bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // sample
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // trimmed_sum, average, difference, blink_period, direction, green_led
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [LIMIT_W-1:0]   cfg_wdata_i;

  baseline_scoreboard sb;
  bit                 calm;
  bit                 hold_req;

  inductive_metal_detect_tracker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5ns;
    clk_i = 1'b1;
    #5ns;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // result side: short random stalls, one long hold on request
  initial begin : result_sink
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(smp);
    do @(posedge clk_i); while (!s_axis_tready);
    sb.fold_sample(smp);
    @(negedge clk_i);
  endtask

  // level runs hover round one reading with jitter and the odd spike
  task automatic send_run(input int n, input bit level_run);
    int lvl, jit, v;
    lvl = $urandom_range(0, FULL_SCALE);
    case ($urandom_range(0, 3))
      0:       jit = 0;
      1:       jit = 1;
      2:       jit = 3;
      default: jit = 24;
    endcase
    repeat (n) begin
      if (!level_run) begin
        v = $urandom_range(0, FULL_SCALE);
      end else if ($urandom_range(0, 39) == 0) begin
        v = $urandom_range(0, 1) ? FULL_SCALE : 0;
      end else begin
        v = lvl - jit + int'($urandom_range(0, 2 * jit));
        if (v < 0) v = 0;
        else if (v > FULL_SCALE) v = FULL_SCALE;
      end
      send_sample(SAMPLE_BITS'(v));
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic new_setting(input logic [CNT_W-1:0] cnt, input logic [LIMIT_W-1:0] lim);
    wait_idle();
    write_reg(REG_SAMPLE_COUNT, LIMIT_W'(cnt));
    write_reg(REG_STEADY_LIMIT, lim);
  endtask

  initial begin : stimulus
    logic [SAMPLE_BITS-1:0] pattern[$];
    logic [CNT_W-1:0]       cnt;
    logic [LIMIT_W-1:0]     lim;
    int                     sent, phase, kind;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_SAMPLE_COUNT;
    cfg_wdata_i   = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // two-sample blocks trim to zero, baseline stays unseeded
    new_setting(CNT_W'(0), '1);
    pattern = '{12'd0, 12'hfff, 12'hfff, 12'hfff};
    foreach (pattern[i]) send_sample(pattern[i]);

    new_setting(CNT_W'(1), '0);
    pattern = '{12'hfff, 12'd0, 12'hfff, 12'd1, 12'hffe, 12'h800,
                12'd0, 12'd0, 12'd0, 12'h800, 12'h800, 12'h800};
    foreach (pattern[i]) send_sample(pattern[i]);

    new_setting(CNT_W'(1), LIMIT_W'(ZERO_PERIOD));
    pattern = '{12'hfff, 12'hfff, 12'hfff, 12'h555, 12'haaa, 12'h7ff};
    foreach (pattern[i]) send_sample(pattern[i]);

    sent  = 0;
    phase = 0;
    while (sent < 1900) begin
      calm = (sent > 1600);
      case ($urandom_range(0, 5))
        0:       lim = '0;
        1:       lim = LIMIT_W'(400);
        2:       lim = LIMIT_W'(ZERO_PERIOD);
        3:       lim = '1;
        4:       lim = LIMIT_W'($urandom_range(0, 3000));
        default: lim = LIMIT_W'($urandom());
      endcase
      kind = $urandom_range(0, 4);
      if (phase == 3) begin
        new_setting(CNT_W'(2), lim);
        hold_req = 1'b1;
        send_run(120, 1'b1);
        sent += 120;
      end else if (phase == 6) begin
        // count above range acts as the largest block
        new_setting('1, lim);
        send_run(MAX_COUNT + 2 + 5, 1'b1);
        sent += MAX_COUNT + 2 + 5;
      end else if (kind == 0) begin
        // empty trimmed sums until the baseline is rebased to zero
        new_setting(CNT_W'(0), lim);
        send_run(140, 1'b0);
        sent += 140;
      end else if (kind == 1) begin
        cnt = CNT_W'($urandom_range(0, 12));
        new_setting(cnt, lim);
        cnt = CNT_W'($urandom_range(40, 200));
        send_run(int'(cnt), 1'b0);
        sent += int'(cnt);
      end else begin
        cnt = CNT_W'($urandom_range(3, 40));
        new_setting(cnt, lim);
        cnt = CNT_W'($urandom_range(60, 200));
        send_run(int'(cnt), 1'b1);
        sent += int'(cnt);
      end
      phase++;
    end

    wait_idle();
    if (sb.failures == 0 && sb.due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
